>>> rtl/assert_macros.svh
// assertion macros used by the record sorter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while reset is applied
`define RSORT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also runs during reset
`define RSORT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/rsort_pkg.sv
// shared types and constants for the record sorter
package rsort_pkg;

    localparam int NUM_W = 11;
    localparam int HEAD_W = 64;
    localparam int TAIL_W = 48;
    localparam int POS_W = 6;
    localparam int HEAD_BYTES = HEAD_W / 8;
    localparam int TAIL_BYTES = TAIL_W / 8;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int NAME_BYTES_DEF = 14;

    // payload carried by every cell
    typedef struct packed {
        logic [NUM_W-1:0]  number;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
        logic [POS_W-1:0]  pos;
    } rec_t;

    // controls broadcast to the cell row
    typedef struct packed {
        logic insert;
        logic shift;
        logic by_name;
    } ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

>>> rtl/record_sorter_by_number_or_name.sv
// record sorter: loads one record per cycle, then streams all held records in key order
// a record is taken every cycle while loading; each is inserted in place on the cell row, or dropped once it is full
// the first result follows the final transfer through the state and output registers, then
// one per cycle unless out_stall holds the output; input stalls from the final transfer until
// the emit state ends; reset clears the control state and the cell valid bits, no clearing pass
`include "assert_macros.svh"

module record_sorter_by_number_or_name #(
    parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF,
    parameter int NAME_BYTES = rsort_pkg::NAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic                         cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rsort_pkg::NUM_W-1:0]  entry_number,
    input  logic [rsort_pkg::HEAD_W-1:0] name_head,
    input  logic [rsort_pkg::TAIL_W-1:0] name_tail,
    input  logic                         is_final,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rsort_pkg::POS_W-1:0]  load_position,
    output logic [rsort_pkg::NUM_W-1:0]  out_entry_number,
    output logic [rsort_pkg::HEAD_W-1:0] out_name_head,
    output logic [rsort_pkg::TAIL_W-1:0] out_name_tail,
    output logic                         end_of_run,
    output logic                         overflow_flag
);
    import rsort_pkg::*;

    localparam int KEY_W = 8 * NAME_BYTES;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    state_t           state_reg;
    state_t           state_next;
    logic             by_name_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [CNT_W-1:0] remaining_reg;
    logic [CNT_W-1:0] remaining_next;
    logic             run_ovf_reg;
    logic             run_ovf_next;

    logic             out_valid_reg;
    rec_t             out_rec_reg;
    logic             out_end_reg;
    logic             out_ovf_reg;

    logic             in_xfer;
    logic             store;
    logic             pop;
    ctl_t             ctl;
    rec_t             new_rec;
    logic [KEY_W-1:0] new_key;

    logic             cell_valid [MAX_RECORDS];
    rec_t             cell_rec   [MAX_RECORDS];
    logic [KEY_W-1:0] cell_key   [MAX_RECORDS];
    logic             cell_less  [MAX_RECORDS];

    // handshake and control decode
    assign in_stall = (state_reg != ST_LOAD);
    assign in_xfer = in_valid && !in_stall;
    assign store = (count_reg != CNT_FULL);
    assign pop = (state_reg == ST_EMIT) && (remaining_reg != '0) &&
                 (!out_valid_reg || !out_stall);

    assign ctl.insert = in_xfer && store;
    assign ctl.shift = pop;
    assign ctl.by_name = by_name_reg;

    assign new_rec.number = entry_number;
    assign new_rec.head = name_head;
    assign new_rec.tail = name_tail;
    assign new_rec.pos = POS_W'(count_reg);

    // normalized name key of the incoming record
    rsort_key_norm #(
        .NAME_BYTES(NAME_BYTES)
    ) u_key_norm (
        .name_head(name_head),
        .name_tail(name_tail),
        .key(new_key)
    );

    // row of sorting cells, smallest key in cell 0
    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        logic             l_valid;
        rec_t             l_rec;
        logic [KEY_W-1:0] l_key;
        logic             l_less;
        logic             r_valid;
        rec_t             r_rec;
        logic [KEY_W-1:0] r_key;

        if (i == 0)
        begin : g_head
            assign l_valid = 1'b0;
            assign l_rec = '0;
            assign l_key = '0;
            assign l_less = 1'b0;
        end
        else
        begin : g_body
            assign l_valid = cell_valid[i-1];
            assign l_rec = cell_rec[i-1];
            assign l_key = cell_key[i-1];
            assign l_less = cell_less[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_rec = '0;
            assign r_key = '0;
        end
        else
        begin : g_mid
            assign r_valid = cell_valid[i+1];
            assign r_rec = cell_rec[i+1];
            assign r_key = cell_key[i+1];
        end

        rsort_cell #(
            .KEY_W(KEY_W)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctl(ctl),
            .new_rec(new_rec),
            .new_key(new_key),
            .left_valid(l_valid),
            .left_rec(l_rec),
            .left_key(l_key),
            .left_less(l_less),
            .right_valid(r_valid),
            .right_rec(r_rec),
            .right_key(r_key),
            .valid(cell_valid[i]),
            .rec(cell_rec[i]),
            .key(cell_key[i]),
            .less(cell_less[i])
        );
    end

    // load and emit sequencing
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        dropped_next = dropped_reg;
        remaining_next = remaining_reg;
        run_ovf_next = run_ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (store)
                    begin
                        count_next = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (is_final)
                    begin
                        state_next = ST_EMIT;
                        remaining_next = store ? (count_reg + CNT_ONE) : count_reg;
                        run_ovf_next = dropped_reg || !store;
                        count_next = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            ST_EMIT:
            begin
                if (remaining_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
                else if (pop)
                begin
                    remaining_next = remaining_reg - CNT_ONE;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            by_name_reg <= 1'b0;
            count_reg <= '0;
            dropped_reg <= 1'b0;
            remaining_reg <= '0;
            run_ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dropped_reg <= dropped_next;
            remaining_reg <= remaining_next;
            run_ovf_reg <= run_ovf_next;
            if (cfg_write_en)
            begin
                by_name_reg <= cfg_write_data;
            end
        end
    end

    // output register, refilled from cell 0 on each pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_rec_reg <= cell_rec[0];
            out_end_reg <= (remaining_reg == CNT_ONE);
            out_ovf_reg <= run_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign load_position = out_rec_reg.pos;
    assign out_entry_number = out_rec_reg.number;
    assign out_name_head = out_rec_reg.head;
    assign out_name_tail = out_rec_reg.tail;
    assign end_of_run = out_end_reg;
    assign overflow_flag = out_ovf_reg;

    // the row is empty whenever a new set starts loading
    `RSORT_ASSERT(a_empty_at_start, ((state_reg == ST_LOAD) && (count_reg == '0)) |-> !cell_valid[0], "cell row not empty at start of set")
    // every record still owed during emission sits in the row
    `RSORT_ASSERT(a_head_valid, ((state_reg == ST_EMIT) && (remaining_reg != '0)) |-> cell_valid[0], "emission ran out of records")
    // counters never pass the capacity
    `RSORT_ASSERT(a_count_bound, (count_reg <= CNT_FULL) && (remaining_reg <= CNT_FULL), "record counter beyond capacity")

endmodule

>>> rtl/rsort_key_norm.sv
// folds a name to lower case and blanks every byte after the first nul
module rsort_key_norm #(
    parameter int NAME_BYTES = rsort_pkg::NAME_BYTES_DEF
) (
    input  logic [rsort_pkg::HEAD_W-1:0] name_head,
    input  logic [rsort_pkg::TAIL_W-1:0] name_tail,
    output logic [8*NAME_BYTES-1:0]      key
);
    import rsort_pkg::*;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // walk the bytes once, tracking whether a nul has been seen
    always_comb
    begin
        logic [7:0] b;
        logic       nul_seen;
        nul_seen = 1'b0;
        key = '0;
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            if (k < HEAD_BYTES)
            begin
                b = name_head[HEAD_W-1-8*k -: 8];
            end
            else
            begin
                b = name_tail[TAIL_W-1-8*(k-HEAD_BYTES) -: 8];
            end
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
            begin
                b = b + CASE_OFFSET;
            end
            if (nul_seen)
            begin
                b = CHAR_NUL;
            end
            if (b == CHAR_NUL)
            begin
                nul_seen = 1'b1;
            end
            key[8*NAME_BYTES-1-8*k -: 8] = b;
        end
    end

endmodule

>>> rtl/rsort_cell.sv
// one compare-and-shift cell of the insertion sort row
module rsort_cell #(
    parameter int KEY_W = 8 * rsort_pkg::NAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsort_pkg::ctl_t              ctl,
    input  rsort_pkg::rec_t              new_rec,
    input  logic [KEY_W-1:0]             new_key,
    input  logic                         left_valid,
    input  rsort_pkg::rec_t              left_rec,
    input  logic [KEY_W-1:0]             left_key,
    input  logic                         left_less,
    input  logic                         right_valid,
    input  rsort_pkg::rec_t              right_rec,
    input  logic [KEY_W-1:0]             right_key,
    output logic                         valid,
    output rsort_pkg::rec_t              rec,
    output logic [KEY_W-1:0]             key,
    output logic                         less
);
    import rsort_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    rec_t             rec_reg;
    rec_t             rec_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    // new record sorts before this one; an empty cell counts as above all keys
    assign less = !valid_reg ||
                  (ctl.by_name ? (new_key < key_reg) : (new_rec.number < rec_reg.number));

    // shift left while emitting, open a gap and insert while loading
    always_comb
    begin
        valid_next = valid_reg;
        rec_next = rec_reg;
        key_next = key_reg;
        priority if (ctl.shift)
        begin
            valid_next = right_valid;
            rec_next = right_rec;
            key_next = right_key;
        end
        else if (ctl.insert && less)
        begin
            if (left_less)
            begin
                valid_next = left_valid;
                rec_next = left_rec;
                key_next = left_key;
            end
            else
            begin
                valid_next = 1'b1;
                rec_next = new_rec;
                key_next = new_key;
            end
        end
        else
        begin
            // hold the current record
            valid_next = valid_reg;
            rec_next = rec_reg;
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        key_reg <= key_next;
    end

    assign valid = valid_reg;
    assign rec = rec_reg;
    assign key = key_reg;

endmodule
